### hw/rtl/fir_pkg.sv
package fir_pkg;

	// Kernel and sample geometry
	localparam int TAPS     = 16;
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 36;
	localparam int CNT_W    = 5;
	localparam int IDX_W    = 4;
	localparam int PROD_W   = 2 * SAMPLE_W;

	// Adder tree shape: leaves padded up to a power of two
	localparam int TREE_LEVELS = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int LEAVES      = 1 << TREE_LEVELS;
	localparam int ACC_W       = PROD_W + TREE_LEVELS;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEF   = 1'b1;

	// Tap count after reset
	localparam logic [CNT_W-1:0] TAP_COUNT_RST = CNT_W'(16);

	// Per-cell control
	typedef struct packed {
		logic load;     // sample transaction: shift history, capture product
		logic clear;    // start of sequence: history tap reads as zero
		logic coef_we;  // coefficient write to this cell
		logic tap_en;   // cell lies below the active tap count
	} fir_cell_ctl_t;

endpackage

### hw/rtl/fir_cell.sv
module fir_cell import fir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fir_cell_ctl_t              ctl,
	input  logic signed [SAMPLE_W-1:0] coef_in,
	input  logic signed [SAMPLE_W-1:0] tap_in,
	output logic signed [SAMPLE_W-1:0] samp_out,
	output logic signed [PROD_W-1:0]   prod_s1
);

	logic signed [SAMPLE_W-1:0] coef_q;
	logic signed [SAMPLE_W-1:0] samp_q;
	logic signed [SAMPLE_W-1:0] opnd;
	logic signed [PROD_W-1:0]   op_a;
	logic signed [PROD_W-1:0]   op_b;
	logic signed [PROD_W-1:0]   prod;

	// Operand for this tap; history before the sequence start is zero
	assign opnd = ctl.clear ? '0 : tap_in;

	// One multiplier per cell
	assign op_a = PROD_W'(coef_q);
	assign op_b = PROD_W'(opnd);
	assign prod = ctl.tap_en ? op_a * op_b : '0;

	// Coefficient and history tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			samp_q <= '0;
		end else begin
			if (ctl.coef_we) begin
				coef_q <= coef_in;
			end
			if (ctl.load) begin
				samp_q <= opnd;
			end
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_s1 <= prod;
		end
	end

	assign samp_out = samp_q;

endmodule

### hw/rtl/fir_add_tree.sv
module fir_add_tree import fir_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [PROD_W-1:0] prod_s1 [TAPS],
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ACC_W-1:0]  sum_out
);

	// node_sk[l] / vld_sk[l] sit in pipeline stage 2+l
	logic                    rdy    [TREE_LEVELS+1];
	logic                    vld_sk [TREE_LEVELS];
	logic signed [ACC_W-1:0] node_sk [TREE_LEVELS][LEAVES/2];
	logic signed [ACC_W-1:0] leaf   [LEAVES];

	// Leaves, zero padded
	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < TAPS) begin : g_used
			assign leaf[i] = ACC_W'(prod_s1[i]);
		end else begin : g_pad
			assign leaf[i] = '0;
		end
	end

	assign rdy[TREE_LEVELS] = !out_stall;
	assign in_ready         = rdy[0];

	for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_lvl
		logic src_v;

		if (l == 0) begin : g_src0
			assign src_v = in_valid;
		end else begin : g_srcn
			assign src_v = vld_sk[l-1];
		end

		// Level moves when empty or when the next level takes its content
		assign rdy[l] = !vld_sk[l] || rdy[l+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[l] <= 1'b0;
			end else if (rdy[l]) begin
				vld_sk[l] <= src_v;
			end
		end

		// Pairwise adds
		for (genvar i = 0; i < (LEAVES >> (l + 1)); i++) begin : g_node
			logic signed [ACC_W-1:0] a;
			logic signed [ACC_W-1:0] b;

			if (l == 0) begin : g_in0
				assign a = leaf[2*i];
				assign b = leaf[2*i+1];
			end else begin : g_inn
				assign a = node_sk[l-1][2*i];
				assign b = node_sk[l-1][2*i+1];
			end

			always_ff @(posedge clk) begin
				if (rdy[l] && src_v) begin
					node_sk[l][i] <= a + b;
				end
			end
		end
	end

	assign out_valid = vld_sk[TREE_LEVELS-1];
	assign sum_out   = node_sk[TREE_LEVELS-1][0];

endmodule

### hw/rtl/causal_fir_convolution_unit.sv
// Channel   Handshake               Payload
// in        in_valid / in_stall     kind, tap_index, value, first
// out       out_valid / out_stall   sum
// cfg       cfg_we                  cfg_wdata (tap_count)
//
// One transaction per cycle on the input while in_stall is low. An accepted
// sample loads the product register in the cell multipliers at the accepting
// edge, then passes through each adder tree level register before out_valid rises.
// Coefficient writes give no result and take effect for the next sample.
// Reset clears coefficients and history and sets tap_count to 16.
// A full stage holds while the stage after it is full and stalled, so empty
// stages keep taking samples while a finished result waits on out_stall.
module causal_fir_convolution_unit import fir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [IDX_W-1:0]           tap_index,
	input  logic signed [SAMPLE_W-1:0] value,
	input  logic                       first,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SUM_W-1:0]    sum,
	input  logic                       cfg_we,
	input  logic [CNT_W-1:0]           cfg_wdata
);

	logic [CNT_W-1:0]           tap_count_q;
	logic                       v_s1_q;
	logic                       rdy_s1;
	logic                       tree_rdy;
	logic                       in_acc;
	logic                       smp_acc;
	logic                       coef_acc;
	logic signed [SAMPLE_W-1:0] x;
	logic signed [SAMPLE_W-1:0] tap_in  [TAPS];
	logic signed [SAMPLE_W-1:0] samp    [TAPS];
	logic signed [PROD_W-1:0]   prod_s1 [TAPS];
	fir_cell_ctl_t              ctl     [TAPS];
	logic signed [ACC_W-1:0]    tree_sum;

	// Tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RST;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// Input handshake
	assign rdy_s1   = !v_s1_q || tree_rdy;
	assign in_stall = !rdy_s1;
	assign in_acc   = in_valid && rdy_s1;
	assign smp_acc  = in_acc && (kind == KIND_SAMPLE);
	assign coef_acc = in_acc && (kind == KIND_COEF);

	assign x = SAMPLE_W'(value);

	// Product stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (rdy_s1) begin
			v_s1_q <= smp_acc;
		end
	end

	// Row of cells; each hands its history sample to the next
	for (genvar j = 0; j < TAPS; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign tap_in[j] = x;
		end else begin : g_body
			assign tap_in[j] = samp[j-1];
		end

		assign ctl[j].load    = smp_acc;
		assign ctl[j].clear   = (j > 0) && first;
		assign ctl[j].coef_we = coef_acc && (32'(tap_index) == j);
		assign ctl[j].tap_en  = 32'(tap_count_q) > j;

		fir_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[j]),
			.coef_in  (x),
			.tap_in   (tap_in[j]),
			.samp_out (samp[j]),
			.prod_s1  (prod_s1[j])
		);
	end

	fir_add_tree u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1_q),
		.in_ready  (tree_rdy),
		.prod_s1   (prod_s1),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sum_out   (tree_sum)
	);

	// Fit accumulator to the result width
	if (ACC_W >= SUM_W) begin : g_cut
		assign sum = tree_sum[SUM_W-1:0];
	end else begin : g_ext
		assign sum = SUM_W'(tree_sum);
	end

	// Coefficient writes never enter the datapath
	a_coef_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		coef_acc |=> !v_s1_q)
		else $error("coefficient write produced a datapath item");

	// Every sample enters the product stage
	a_smp_enters: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> v_s1_q)
		else $error("accepted sample missing from product stage");

	// No taps in use gives a zero product at the head
	a_zero_taps: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_acc && (tap_count_q == '0)) |=> (prod_s1[0] == '0))
		else $error("product nonzero with tap count zero");

	// Start of sequence clears the history held past the head cell
	if (TAPS > 1) begin : g_a_first
		a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
			(smp_acc && first) |=> (samp[1] == '0))
			else $error("history not cleared at sequence start");
	end

endmodule

### sim/causal_fir_convolution_unit_test.sv
module causal_fir_convolution_unit_test;
	import fir_pkg::*;

	localparam int LATENCY        = TREE_LEVELS + 1;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_RARE, RX_BUSY} rx_mode_t;
	typedef enum int {SEQ_RELOAD, SEQ_CONTINUE, SEQ_FULL_SCALE, SEQ_NOISE} traffic_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       kind;
	logic [IDX_W-1:0]           tap_index;
	logic signed [SAMPLE_W-1:0] value;
	logic                       first;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SUM_W-1:0]    sum;
	logic                       cfg_we;
	logic [CNT_W-1:0]           cfg_wdata;

	// filter state as the block should hold it
	logic signed [SAMPLE_W-1:0] kernel [TAPS];
	logic signed [SAMPLE_W-1:0] past [TAPS-1];
	logic [CNT_W-1:0]           tap_limit;
	logic signed [SUM_W-1:0]    expected_sums [$];

	int       errors;
	int       items_sent;
	int       stuck_cycles;
	bit       gaps_on;
	int       burst_left;
	logic     hold_request;
	int       hold_left;
	rx_mode_t rx_mode;
	int       rx_left;

	causal_fir_convolution_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.tap_index (tap_index),
		.value     (value),
		.first     (first),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sum       (sum),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// expected sum for one accepted transaction; coefficient writes only update the kernel
	function automatic void filter_step(input logic item_kind,
			input logic [IDX_W-1:0] idx, input logic signed [SAMPLE_W-1:0] x,
			input logic restart);
		longint acc;
		int     active;
		acc = 0;
		if (item_kind == KIND_COEF) begin
			kernel[idx] = x;
			return;
		end
		if (restart)
			foreach (past[j]) past[j] = '0;
		active = (tap_limit > TAPS) ? TAPS : int'(tap_limit);
		if (active > 0)
			acc = longint'(x) * longint'(kernel[0]);
		for (int j = 1; j < active; j++)
			acc += longint'(past[j-1]) * longint'(kernel[j]);
		for (int j = TAPS - 2; j > 0; j--)
			past[j] = past[j-1];
		past[0] = x;
		expected_sums.push_back(SUM_W'(acc));
	endfunction

	// corner values turn up often, the rest is uniform
	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// sender gaps: random bursts, now and then a long stretch with no gap
	task automatic pace();
		int gap;
		if (!gaps_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
		                                          : $urandom_range(0, 12);
		gap = $urandom_range(1, 5);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// offer one transaction and hold it until accepted
	task automatic send_item(input logic item_kind, input logic [IDX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] x, input logic restart);
		in_valid  <= 1'b1;
		kind      <= item_kind;
		tap_index <= idx;
		value     <= x;
		first     <= restart;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		filter_step(item_kind, idx, x, restart);
		items_sent++;
		pace();
	endtask

	// sender pauses until every result is back and the pipe has emptied
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_tap_count(input logic [CNT_W-1:0] count);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tap_limit = count;
	endtask

	// mostly well-formed kernel loads and sample runs, some noise
	task automatic run_traffic(input int n);
		int                         start;
		int                         len;
		int                         pick;
		traffic_t                   seq;
		logic signed [SAMPLE_W-1:0] c;
		logic signed [SAMPLE_W-1:0] s;
		start = items_sent;
		while (items_sent - start < n) begin
			pick = $urandom_range(0, 99);
			seq  = (pick < 40) ? SEQ_RELOAD : (pick < 75) ? SEQ_CONTINUE :
			       (pick < 85) ? SEQ_FULL_SCALE : SEQ_NOISE;
			case (seq)
				SEQ_RELOAD: begin
					repeat ($urandom_range(1, 6))
						send_item(KIND_COEF, IDX_W'($urandom), pick_value(),
							1'($urandom));
					len = $urandom_range(1, 40);
					for (int i = 0; i < len; i++)
						send_item(KIND_SAMPLE, IDX_W'($urandom), pick_value(), i == 0);
				end
				SEQ_CONTINUE: begin
					repeat ($urandom_range(1, 30))
						send_item(KIND_SAMPLE, IDX_W'($urandom), pick_value(), 1'b0);
				end
				SEQ_FULL_SCALE: begin
					// every tap and every sample at a rail: largest magnitude sums
					c = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
					s = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
					for (int j = 0; j < TAPS; j++)
						send_item(KIND_COEF, IDX_W'(j), c, 1'($urandom));
					len = $urandom_range(TAPS, TAPS + 8);
					for (int i = 0; i < len; i++)
						send_item(KIND_SAMPLE, IDX_W'($urandom), s, i == 0);
				end
				default: begin
					repeat ($urandom_range(1, 10))
						send_item(1'($urandom), IDX_W'($urandom), SAMPLE_W'($urandom),
							1'($urandom));
				end
			endcase
		end
	endtask

	task automatic test_directed();
		logic signed [SAMPLE_W-1:0] corner [4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
		// kernel is all zero after reset
		send_item(KIND_SAMPLE, 4'd0, 16'sh7fff, 1'b1);
		// first flag on a coefficient write must not touch history
		send_item(KIND_COEF, 4'd0, 16'sd1, 1'b1);
		send_item(KIND_COEF, 4'd1, -16'sd1, 1'b0);
		send_item(KIND_COEF, 4'd7, 16'sh8000, 1'b0);
		send_item(KIND_COEF, 4'd15, 16'sh7fff, 1'b1);
		// sixteen samples so the last tap sees data
		for (int i = 0; i < TAPS; i++)
			send_item(KIND_SAMPLE, 4'hf, corner[i % 4], i == 0);
		// restart in the middle of a run
		send_item(KIND_SAMPLE, 4'd9, 16'sh7fff, 1'b1);
		send_item(KIND_SAMPLE, 4'd0, 16'sh8000, 1'b0);
	endtask

	// zero taps, one tap, counts above the kernel size, the full kernel
	task automatic test_tap_counts();
		logic [CNT_W-1:0] counts [5] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd16};
		foreach (counts[i]) begin
			set_tap_count(counts[i]);
			run_traffic(60);
		end
	endtask

	// receiver holds off while the sender keeps pushing, so the input stalls
	task automatic test_backpressure();
		set_tap_count(TAP_COUNT_RST);
		hold_request = 1'b1;
		gaps_on      = 1'b0;
		run_traffic(100);
		gaps_on      = 1'b1;
		drain_results();
	endtask

	task automatic test_random_stream();
		repeat (8) begin
			set_tap_count(CNT_W'($urandom_range(0, 31)));
			run_traffic(70);
		end
	endtask

	task automatic finish_run();
		in_valid <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (4 * LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	endtask

	// receiver stall pattern, with a long hold on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			out_stall    <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(8, 60);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_COIN: out_stall <= 1'($urandom);
				RX_RARE: out_stall <= ($urandom_range(0, 7) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// compare each accepted result with the oldest expected sum
	always @(posedge clk) begin
		logic signed [SUM_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, sum);
				errors++;
			end else begin
				want = expected_sums.pop_front();
				if (sum !== want) begin
					$display("%0t: sum mismatch, expected %0d, actual %0d", $time, want, sum);
					errors++;
				end
			end
		end
	end

	// end the run if no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_SAMPLE;
		tap_index    = '0;
		value        = '0;
		first        = 1'b0;
		out_stall    = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = TAP_COUNT_RST;
		hold_request = 1'b0;
		hold_left    = 0;
		rx_mode      = RX_FREE;
		rx_left      = 0;
		gaps_on      = 1'b1;
		burst_left   = 0;
		errors       = 0;
		items_sent   = 0;
		stuck_cycles = 0;
		foreach (kernel[j]) kernel[j] = '0;
		foreach (past[j]) past[j] = '0;
		tap_limit = TAP_COUNT_RST;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_tap_counts();
		test_backpressure();
		test_random_stream();
		finish_run();
	end

endmodule
